// ===== hdl/timed_fifo_decision_cache_unit_macros.svh =====
// Assertion macros used by the checker of the decision cache.
`ifndef TIMED_FIFO_DECISION_CACHE_UNIT_MACROS_SVH
`define TIMED_FIFO_DECISION_CACHE_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TFDC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define TFDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/tfdc_pkg.sv =====
// Types and constants of the timed decision cache.
package tfdc_pkg;

    localparam int CAPACITY   = 256;
    localparam int SLOT_W     = $clog2(CAPACITY);
    localparam int COUNT_W    = SLOT_W + 1;
    localparam int KEY_W      = 22;
    localparam int STAMP_W    = 32;
    localparam int TIMEOUT_W  = 16;
    localparam int LIMIT_W    = 9;
    localparam int KIND_W     = 2;
    localparam int TIMEOUT_RST = 30;
    localparam int LIMIT_RST   = 256;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK       = 2'd0,
        KIND_LOOKUP     = 2'd1,
        KIND_INSERT     = 2'd2,
        KIND_INVALIDATE = 2'd3
    } kind_t;

    typedef enum logic {
        REG_TIMEOUT = 1'b0,
        REG_LIMIT   = 1'b1
    } reg_index_t;

    // Access request from the control sequencer to the entry store.
    typedef struct packed {
        logic               rd_en;
        logic [SLOT_W-1:0]  rd_addr;
        logic               data_we;
        logic [SLOT_W-1:0]  data_addr;
        logic [KEY_W-1:0]   key;
        logic               decision;
        logic [STAMP_W-1:0] stamp;
        logic               link_we;
        logic [SLOT_W-1:0]  link_addr;
        logic [SLOT_W-1:0]  link_val;
    } store_req_t;

    // Registered read data of one entry.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic               decision;
        logic [STAMP_W-1:0] stamp;
        logic [SLOT_W-1:0]  link;
    } store_rd_t;

endpackage

// ===== hdl/tfdc_store.sv =====
// Entry store: per-slot key, decision, stamp and order link memories.
module tfdc_store (
    input  logic                aclk,
    input  tfdc_pkg::store_req_t req,
    output tfdc_pkg::store_rd_t  rd
);

    logic [tfdc_pkg::KEY_W-1:0]   key_mem   [tfdc_pkg::CAPACITY];
    logic                         dec_mem   [tfdc_pkg::CAPACITY];
    logic [tfdc_pkg::STAMP_W-1:0] stamp_mem [tfdc_pkg::CAPACITY];
    logic [tfdc_pkg::SLOT_W-1:0]  link_mem  [tfdc_pkg::CAPACITY];

    always_ff @(posedge aclk) begin
        if (req.data_we) begin
            key_mem[req.data_addr]   <= req.key;
            dec_mem[req.data_addr]   <= req.decision;
            stamp_mem[req.data_addr] <= req.stamp;
        end
        if (req.link_we) begin
            link_mem[req.link_addr] <= req.link_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd.key      <= key_mem[req.rd_addr];
            rd.decision <= dec_mem[req.rd_addr];
            rd.stamp    <= stamp_mem[req.rd_addr];
            rd.link     <= link_mem[req.rd_addr];
        end
    end

endmodule

// ===== hdl/timed_fifo_decision_cache_unit.sv =====
// Top level of the timed FIFO decision cache with time-to-live expiry.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------
//  s_       | in        | tuser: kind; tdata: key, decision_in
//  m_       | out       | tdata: hit, decision_out, entry_count
//  cfg_     | in        | cfg_index selects timeout_ticks or the entry limit
//
// Tick: IDLE, then DONE. Lookup/invalidate: IDLE reads the head, CMP walks the
// order list, at most count entries, one read of the entry store per entry, then
// DONE. Insert: IDLE, EVICT at the limit, then FREE probes valid bits in the
// free-slot scan (at most CAPACITY), then DONE. Reset is synchronous and clears
// the valid bits at once; no clearing pass. One item is in work at a time; a
// finished result waits in the output register while the next item enters.
module timed_fifo_decision_cache_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [21:0] key, [22] decision_in, [23] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] hit, [1] decision_out, [10:2] entry_count
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int SW = tfdc_pkg::SLOT_W;
    localparam int CW = tfdc_pkg::COUNT_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CMP   = 6'b000010,
        S_EVICT = 6'b000100,
        S_FREE  = 6'b001000,
        S_DONE  = 6'b010000,
        S_SPARE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [tfdc_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [tfdc_pkg::LIMIT_W-1:0]   limit_reg;

    logic [tfdc_pkg::CAPACITY-1:0] valid_reg, valid_next;
    logic [SW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [tfdc_pkg::STAMP_W-1:0] time_reg, time_next;

    // item in work
    tfdc_pkg::kind_t kind_reg, kind_next;
    logic [tfdc_pkg::KEY_W-1:0] key_reg, key_next;
    logic dec_reg, dec_next;
    logic [SW-1:0] cur_reg, cur_next, prev_reg, prev_next;
    logic has_prev_reg, has_prev_next;
    logic [CW-1:0] walk_reg, walk_next;
    logic hit_reg, hit_next, dout_reg, dout_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [15:0] m_data_reg, m_data_next;

    tfdc_pkg::store_req_t req;
    tfdc_pkg::store_rd_t  rd;

    logic [CW-1:0] limit_eff;
    logic [tfdc_pkg::STAMP_W-1:0] age;
    logic in_fire;

    tfdc_store u_store (
        .aclk (aclk),
        .req  (req),
        .rd   (rd)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Clamp the limit into 1..CAPACITY.
    always_comb begin
        if (limit_reg == '0) begin
            limit_eff = CW'(1);
        end else if (CW'(limit_reg) > CW'(tfdc_pkg::CAPACITY)) begin
            limit_eff = CW'(tfdc_pkg::CAPACITY);
        end else begin
            limit_eff = CW'(limit_reg);
        end
    end

    assign age = time_reg - rd.stamp;

    always_comb begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        time_next     = time_reg;
        kind_next     = kind_reg;
        key_next      = key_reg;
        dec_next      = dec_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        has_prev_next = has_prev_reg;
        walk_next     = walk_reg;
        hit_next      = hit_reg;
        dout_next     = dout_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        req           = '0;

        // drain the output register
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    kind_next     = tfdc_pkg::kind_t'(s_tuser);
                    key_next      = s_tdata[tfdc_pkg::KEY_W-1:0];
                    dec_next      = s_tdata[tfdc_pkg::KEY_W];
                    hit_next      = 1'b0;
                    dout_next     = 1'b0;
                    cur_next      = head_reg;
                    has_prev_next = 1'b0;
                    walk_next     = '0;
                    state_next    = S_DONE;
                    case (tfdc_pkg::kind_t'(s_tuser))
                        tfdc_pkg::KIND_TICK: begin
                            time_next = time_reg + 1'b1;
                        end
                        tfdc_pkg::KIND_INSERT: begin
                            if (count_reg >= limit_eff && count_reg != '0) begin
                                // fetch the head's link before dropping it
                                req.rd_en   = 1'b1;
                                req.rd_addr = head_reg;
                                state_next  = S_EVICT;
                            end else begin
                                cur_next   = '0;
                                state_next = S_FREE;
                            end
                        end
                        default: begin
                            if (tfdc_pkg::kind_t'(s_tuser) == tfdc_pkg::KIND_INVALIDATE &&
                                s_tdata[tfdc_pkg::KEY_W-1:0] == '0) begin
                                valid_next = '0;
                                head_next  = '0;
                                tail_next  = '0;
                                count_next = '0;
                            end else if (count_reg != '0) begin
                                req.rd_en   = 1'b1;
                                req.rd_addr = head_reg;
                                state_next  = S_CMP;
                            end
                        end
                    endcase
                end
            end

            S_CMP: begin
                state_next = S_DONE;
                if (!valid_reg[cur_reg]) begin
                    // broken chain: stop walking
                end else if (rd.key == key_reg) begin
                    if (kind_reg == tfdc_pkg::KIND_LOOKUP &&
                        age < tfdc_pkg::STAMP_W'(timeout_reg)) begin
                        hit_next  = 1'b1;
                        dout_next = rd.decision;
                    end else begin
                        // unlink the matched slot
                        if (has_prev_reg) begin
                            req.link_we   = 1'b1;
                            req.link_addr = prev_reg;
                            req.link_val  = rd.link;
                        end else begin
                            head_next = rd.link;
                        end
                        if (cur_reg == tail_reg) begin
                            tail_next = has_prev_reg ? prev_reg : '0;
                        end
                        valid_next[cur_reg] = 1'b0;
                        count_next = count_reg - 1'b1;
                        if (count_reg == CW'(1)) begin
                            head_next = '0;
                            tail_next = '0;
                        end
                    end
                end else if ((CW+1)'(walk_reg) + 1'b1 < (CW+1)'(count_reg)) begin
                    // advance along the order list
                    prev_next     = cur_reg;
                    has_prev_next = 1'b1;
                    cur_next      = rd.link;
                    walk_next     = walk_reg + 1'b1;
                    req.rd_en     = 1'b1;
                    req.rd_addr   = rd.link;
                    state_next    = S_CMP;
                end
            end

            S_EVICT: begin
                head_next = rd.link;
                if (head_reg == tail_reg) begin
                    tail_next = '0;
                end
                valid_next[head_reg] = 1'b0;
                count_next = count_reg - 1'b1;
                if (count_reg == CW'(1)) begin
                    head_next = '0;
                    tail_next = '0;
                end
                cur_next   = '0;
                state_next = S_FREE;
            end

            S_FREE: begin
                if (!valid_reg[cur_reg]) begin
                    req.data_we   = 1'b1;
                    req.data_addr = cur_reg;
                    req.key       = key_reg;
                    req.decision  = dec_reg;
                    req.stamp     = time_reg;
                    if (count_reg != '0) begin
                        req.link_we   = 1'b1;
                        req.link_addr = tail_reg;
                        req.link_val  = cur_reg;
                    end else begin
                        head_next = cur_reg;
                    end
                    tail_next           = cur_reg;
                    valid_next[cur_reg] = 1'b1;
                    count_next          = count_reg + 1'b1;
                    state_next          = S_DONE;
                end else begin
                    cur_next = cur_reg + 1'b1;
                end
            end

            S_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'd0, count_reg, dout_reg, hit_reg};
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            time_reg    <= '0;
            m_valid_reg <= 1'b0;
            timeout_reg <= tfdc_pkg::TIMEOUT_W'(tfdc_pkg::TIMEOUT_RST);
            limit_reg   <= tfdc_pkg::LIMIT_W'(tfdc_pkg::LIMIT_RST);
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            time_reg    <= time_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (tfdc_pkg::reg_index_t'(cfg_index))
                    tfdc_pkg::REG_TIMEOUT: timeout_reg <= cfg_data;
                    tfdc_pkg::REG_LIMIT:   limit_reg <= cfg_data[tfdc_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        key_reg      <= key_next;
        dec_reg      <= dec_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        has_prev_reg <= has_prev_next;
        walk_reg     <= walk_next;
        hit_reg      <= hit_next;
        dout_reg     <= dout_next;
        m_data_reg   <= m_data_next;
    end

endmodule

// ===== hdl/tfdc_checker.sv =====
// Port-level checker of the decision cache, bound to the top level.
`include "timed_fifo_decision_cache_unit_macros.svh"

module tfdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    `TFDC_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
    `TFDC_ASSERT(a_count_range, aclk, aresetn, m_tvalid |-> m_tdata[10:2] <= 9'd256, "entry count above capacity")
    `TFDC_ASSERT(a_dec_needs_hit, aclk, aresetn, m_tvalid && m_tdata[1] |-> m_tdata[0], "decision shown without a hit")
    `TFDC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result present after reset")

endmodule

bind timed_fifo_decision_cache_unit tfdc_checker u_tfdc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
